/* sv/celcs_pkg.sv */
// ----------------------------------------------------------------------------
// celcs_pkg
// Shared types and constants for the circular event log core.
// ----------------------------------------------------------------------------
package celcs_pkg;

    localparam logic [1:0] REQ_LOG     = 2'd0;
    localparam logic [1:0] REQ_BEGIN   = 2'd1;
    localparam logic [1:0] REQ_READOUT = 2'd2;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_PRIV  = 2'd1;
    localparam logic [1:0] CFG_TYPE  = 2'd2;

    localparam logic [7:0] CHAR_MASK  = 8'h7F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0]  priv;
        logic [7:0]  kind;
        logic [31:0] text;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] tstamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HEADER,
        ST_WALK,
        ST_EMIT
    } state_t;

    // shift control handed to every cell
    typedef struct packed {
        logic rotate;  // all cells pass data one place towards cell 0
        logic push;    // new entry enters at the tail
    } cell_ctl_t;

    function automatic logic [31:0] cut_text(input logic [31:0] t);
        logic [31:0] r;
        logic        ended;
        r = '0;
        ended = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (t[8*k +: 8] == 8'd0) ended = 1'b1;
            if (!ended) r[8*k +: 8] = t[8*k +: 8];
        end
        return r;
    endfunction

    function automatic logic [31:0] sanitize(input logic [31:0] t);
        logic [31:0] r;
        logic        ended;
        logic [7:0]  c;
        r = '0;
        ended = 1'b0;
        for (int k = 0; k < 4; k++) begin
            c = t[8*k +: 8];
            if (c == 8'd0) ended = 1'b1;
            if (ended) begin
                c = CHAR_SPACE;
            end else begin
                c = c & CHAR_MASK;
                if (c < CHAR_SPACE) c = CHAR_SPACE;
            end
            r[8*k +: 8] = c;
        end
        return r;
    endfunction

endpackage

/* sv/celcs_cell.sv */
// ----------------------------------------------------------------------------
// celcs_cell
// One slot of the entry chain: holds an entry and takes its neighbour's.
// ----------------------------------------------------------------------------
module celcs_cell (
    input  logic                 aclk,
    input  celcs_pkg::cell_ctl_t ctl,
    input  celcs_pkg::entry_t    from_up,
    input  celcs_pkg::entry_t    wrap_in,
    input  logic                 take_wrap,
    output celcs_pkg::entry_t    data
);
    celcs_pkg::entry_t data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.rotate) begin
            data_reg <= take_wrap ? wrap_in : from_up;
        end else if (ctl.push) begin
            data_reg <= from_up;
        end
    end

    assign data = data_reg;
endmodule

/* sv/circular_event_log_with_client_search_core.sv */
// ----------------------------------------------------------------------------
// circular_event_log_with_client_search_core
// Event log of LOG_DEPTH-1 entries kept in a shifting chain of cells,
// oldest at cell 0; client search and readout rotate the chain once.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_      | in  | tvalid/tready      | tdata: request fields, tuser=req_type
// m_      | out | tvalid/tready      | tdata, tuser=is_header, tlast=last
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// Log event: one push. Request begin: one rotation step per stored entry,
// then a push if no stored entry matched; only the push when the log is empty.
// Readout: header, then one rotation step per stored entry; output stalls
// hold the rotation.
// Reset (aresetn low, synchronous) empties the log; entry data needs no clear.
// A held m_ item with m_tready low freezes the readout walk; no item accepted while busy.
// ----------------------------------------------------------------------------
module circular_event_log_with_client_search_core #(
    parameter int LOG_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // privilege[7:0] log_type[15:8] value_text[47:16] has_client[48]
    // client_ip[80:49] client_mac[128:81] now_seconds[160:129]
    // viewer_is_super[161]
    input  logic [167:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // time_value[31:0] entry_type[39:32] entry_text[71:40] entry_ip[103:72]
    // entry_mac[151:104]
    output logic [151:0] m_tdata,
    // is_header[0]
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int NC = LOG_DEPTH - 1;
    localparam int CW = $clog2(LOG_DEPTH);

    logic [31:0] start_reg;
    logic [7:0]  ncpriv_reg, nctype_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            ncpriv_reg <= '0;
            nctype_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                celcs_pkg::CFG_START: start_reg  <= cfg_data;
                celcs_pkg::CFG_PRIV:  ncpriv_reg <= cfg_data[7:0];
                celcs_pkg::CFG_TYPE:  nctype_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // latched request
    logic [163:0] req_reg;
    logic [1:0]   r_type;
    logic [31:0]  r_ip, r_now;
    logic [47:0]  r_mac;
    logic         r_super;
    assign r_type  = req_reg[1:0];
    assign r_ip    = req_reg[82:51];
    assign r_mac   = req_reg[130:83];
    assign r_now   = req_reg[162:131];
    assign r_super = req_reg[163];

    celcs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;  // stored entries, up to NC
    logic [CW-1:0] step_reg, step_next;    // rotation steps done
    logic          found_reg, found_next;
    logic          out_v_reg;
    logic [151:0]  out_d_reg;
    logic          out_h_reg, out_l_reg;

    celcs_pkg::cell_ctl_t ctl;
    celcs_pkg::entry_t    cells [NC];
    celcs_pkg::entry_t    new_e;
    logic [CW-1:0]        tail;   // cell receiving a push
    logic                 full;

    assign full = (count_reg == CW'(NC));
    assign tail = full ? CW'(NC - 1) : count_reg;

    // entry built from the latched request
    always_comb begin
        new_e.priv   = req_reg[9:2];
        new_e.kind   = req_reg[17:10];
        new_e.text   = celcs_pkg::cut_text(req_reg[49:18]);
        new_e.ip     = req_reg[50] ? r_ip : 32'd0;
        new_e.mac    = req_reg[50] ? r_mac : 48'd0;
        new_e.tstamp = r_now - start_reg;
        if (r_type == celcs_pkg::REQ_BEGIN) begin
            new_e.priv = ncpriv_reg;
            new_e.kind = nctype_reg;
            new_e.text = '0;
            new_e.ip   = r_ip;
            new_e.mac  = r_mac;
        end
    end

    // chain: cell i takes cell i+1; on push, tail cell takes the new entry
    // (when full every cell shifts down, dropping the oldest)
    for (genvar i = 0; i < NC; i++) begin : g_cell
        celcs_pkg::cell_ctl_t c_ctl;
        celcs_pkg::entry_t    up;
        always_comb begin
            c_ctl.rotate = ctl.rotate;
            c_ctl.push   = ctl.push && (full || CW'(i) == tail);
            if (ctl.push && CW'(i) == tail) up = new_e;
            else if (i == NC - 1)            up = new_e;
            else                             up = cells[(i + 1) % NC];
        end
        celcs_cell u_cell (
            .aclk      (aclk),
            .ctl       (c_ctl),
            .from_up   (up),
            .wrap_in   (cells[0]),
            .take_wrap (ctl.rotate && CW'(i) == count_reg - CW'(1)),
            .data      (cells[i])
        );
    end

    logic head_match, head_vis, out_free, last_step;
    assign head_match = (cells[0].ip == r_ip) && (cells[0].mac == r_mac);
    assign head_vis   = r_super || (cells[0].priv != 8'd0);
    assign out_free   = !out_v_reg || m_tready;
    assign last_step  = (step_reg == count_reg - CW'(1));

    logic emit_hdr, emit_ent;
    assign emit_hdr = (state_reg == celcs_pkg::ST_HEADER) && out_free;
    assign emit_ent = (state_reg == celcs_pkg::ST_WALK) && out_free && head_vis;

    // any visible entry after the current one in this readout pass
    logic more_vis;
    always_comb begin
        more_vis = 1'b0;
        for (int i = 1; i < NC; i++) begin
            if (CW'(i) < count_reg - step_reg &&
                (r_super || cells[i].priv != 8'd0)) more_vis = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            celcs_pkg::ST_IDLE:
                if (s_tvalid) begin
                    unique case (s_tuser)
                        celcs_pkg::REQ_LOG:     state_next = celcs_pkg::ST_EMIT;
                        celcs_pkg::REQ_BEGIN:   state_next = celcs_pkg::ST_SEARCH;
                        celcs_pkg::REQ_READOUT: state_next = celcs_pkg::ST_HEADER;
                        default:                state_next = celcs_pkg::ST_IDLE;
                    endcase
                end
            celcs_pkg::ST_SEARCH:
                if (count_reg == '0 || (last_step && !found_reg && !head_match))
                    state_next = celcs_pkg::ST_EMIT;
                else if (last_step)
                    state_next = celcs_pkg::ST_IDLE;
            celcs_pkg::ST_HEADER:
                if (out_free)
                    state_next = (count_reg == '0) ? celcs_pkg::ST_IDLE
                                                   : celcs_pkg::ST_WALK;
            celcs_pkg::ST_WALK:
                if (out_free && last_step) state_next = celcs_pkg::ST_IDLE;
            celcs_pkg::ST_EMIT:
                state_next = celcs_pkg::ST_IDLE;
            default: state_next = celcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl        = '0;
        count_next = count_reg;
        step_next  = step_reg;
        found_next = found_reg;
        s_tready   = (state_reg == celcs_pkg::ST_IDLE);
        unique case (state_reg)
            celcs_pkg::ST_IDLE: begin
                step_next  = '0;
                found_next = 1'b0;
            end
            celcs_pkg::ST_SEARCH:
                if (count_reg != '0) begin
                    ctl.rotate = 1'b1;
                    step_next  = step_reg + CW'(1);
                    if (head_match) found_next = 1'b1;
                end
            celcs_pkg::ST_WALK:
                if (out_free) begin
                    ctl.rotate = 1'b1;
                    step_next  = step_reg + CW'(1);
                end
            celcs_pkg::ST_EMIT: begin
                ctl.push = 1'b1;
                if (!full) count_next = count_reg + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= celcs_pkg::ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            if (emit_hdr || emit_ent) out_v_reg <= 1'b1;
            else if (m_tready)        out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) req_reg <= {s_tdata[161:0], s_tuser};
        if (state_reg == celcs_pkg::ST_HEADER && out_free) begin
            out_d_reg <= {120'd0, r_now - start_reg};
            out_h_reg <= 1'b1;
            out_l_reg <= (count_reg == '0) || !(r_super || more_vis ||
                         cells[0].priv != 8'd0);
        end else if (state_reg == celcs_pkg::ST_WALK && out_free && head_vis) begin
            out_d_reg <= {cells[0].mac, cells[0].ip,
                          celcs_pkg::sanitize(cells[0].text), cells[0].kind,
                          cells[0].tstamp};
            out_h_reg <= 1'b0;
            out_l_reg <= !more_vis;
        end
    end

    // header's lookahead: any visible entry at all (step is zero in header)
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_h_reg;
    assign m_tlast  = out_l_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(NC)) else $error("entry count overflow");
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != celcs_pkg::ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == celcs_pkg::ST_EMIT && !full) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push lost");
endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circular event log core: logs events, runs
// client searches and readouts, predicts every readout item and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        is_header;
        logic [31:0] tval;
        logic [7:0]  kind;
        logic [31:0] text;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        last;
    } view_t;

    typedef struct {
        logic [1:0]  req;
        logic [7:0]  priv;
        logic [7:0]  kind;
        logic [31:0] text;
        logic        has_client;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] now;
        logic        super_v;
    } request_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = celcs_pkg::CFG_START;
    logic [31:0]  cfg_data = '0;

    circular_event_log_with_client_search_core #(.LOG_DEPTH(DEPTH)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [31:0]       start_sec;
    logic [7:0]        nc_priv, nc_kind;
    celcs_pkg::entry_t ring [DEPTH];
    int                oldest, next_slot;

    request_t    pending_reqs [$];
    view_t       expected_views [$];
    int          errors = 0, n_views = 0, n_readouts = 0, n_sent = 0;
    int          tx_idle = 17, rx_idle = 81;
    int          quiet = 0;

    function automatic logic [31:0] keep_text(logic [31:0] t);
        logic [31:0] r;
        logic        ended;
        r = '0;
        ended = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (t[8*k +: 8] == 8'd0) ended = 1'b1;
            if (!ended) r[8*k +: 8] = t[8*k +: 8];
        end
        return r;
    endfunction

    function automatic logic [31:0] clean_text(logic [31:0] t);
        logic [31:0] r;
        logic        ended;
        logic [7:0]  c;
        r = '0;
        ended = 1'b0;
        for (int k = 0; k < 4; k++) begin
            c = t[8*k +: 8];
            if (c == 8'd0) ended = 1'b1;
            if (ended) c = 8'h20;
            else begin
                c = c & 8'h7F;
                if (c < 8'h20) c = 8'h20;
            end
            r[8*k +: 8] = c;
        end
        return r;
    endfunction

    task automatic log_entry(logic [7:0] p, logic [7:0] k, logic [31:0] t,
                             logic [31:0] ip, logic [47:0] mac, logic [31:0] now);
        int after;
        after = (next_slot + 1) % DEPTH;
        if (oldest == after) oldest = (oldest + 1) % DEPTH;
        ring[next_slot] = '{priv: p, kind: k, text: keep_text(t), ip: ip,
                            mac: mac, tstamp: now - start_sec};
        next_slot = after;
    endtask

    task automatic predict_log(request_t r);
        bit   found;
        view_t v;
        case (r.req)
            celcs_pkg::REQ_LOG: begin
                if (r.has_client) log_entry(r.priv, r.kind, r.text, r.ip, r.mac, r.now);
                else log_entry(r.priv, r.kind, r.text, '0, '0, r.now);
            end
            celcs_pkg::REQ_BEGIN: begin
                found = 0;
                for (int i = oldest; i != next_slot; i = (i + 1) % DEPTH)
                    if (ring[i].ip == r.ip && ring[i].mac == r.mac) found = 1;
                if (!found) log_entry(nc_priv, nc_kind, '0, r.ip, r.mac, r.now);
            end
            celcs_pkg::REQ_READOUT: begin
                n_readouts++;
                expected_views.push_back('{1'b1, r.now - start_sec, 8'd0, 32'd0,
                                           32'd0, 48'd0, 1'b0});
                for (int i = oldest; i != next_slot; i = (i + 1) % DEPTH)
                    if (r.super_v || ring[i].priv != 8'd0) begin
                        v = '{1'b0, ring[i].tstamp, ring[i].kind,
                              clean_text(ring[i].text), ring[i].ip, ring[i].mac, 1'b0};
                        expected_views.push_back(v);
                    end
                expected_views[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // set when the item on the input was taken at the last rising edge
    logic in_taken = 1'b0;
    always @(posedge aclk) in_taken <= s_tvalid && s_tready;

    // driver: predicts as each item is presented, items keep their order
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle) begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    s_tdata <= {6'd0, r.super_v, r.now, r.mac, r.ip, r.has_client,
                                r.text, r.kind, r.priv};
                    s_tuser <= r.req;
                    s_tvalid <= 1'b1;
                    predict_log(r);
                    n_sent++;
                end else s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (m_tvalid && m_tready) begin
                view_t w;
                n_views++;
                if (expected_views.size() == 0)
                    report("unexpected item", m_tdata[63:0], '0);
                else begin
                    w = expected_views.pop_front();
                    if (m_tuser !== w.is_header)
                        report("is_header", 64'(m_tuser), 64'(w.is_header));
                    if (m_tdata[31:0] !== w.tval)
                        report("time_value", 64'(m_tdata[31:0]), 64'(w.tval));
                    if (m_tdata[39:32] !== w.kind)
                        report("entry_type", 64'(m_tdata[39:32]), 64'(w.kind));
                    if (m_tdata[71:40] !== w.text)
                        report("entry_text", 64'(m_tdata[71:40]), 64'(w.text));
                    if (m_tdata[103:72] !== w.ip)
                        report("entry_ip", 64'(m_tdata[103:72]), 64'(w.ip));
                    if (m_tdata[151:104] !== w.mac)
                        report("entry_mac", 64'(m_tdata[151:104]), 64'(w.mac));
                    if (m_tlast !== w.last)
                        report("last", 64'(m_tlast), 64'(w.last));
                end
            end
            if (quiet >= STALL_LIMIT) begin
                $display("Watchdog expired: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic request_t make_req(logic [1:0] req, logic [31:0] ip, logic [47:0] mac);
        request_t r;
        r.req = req;
        r.priv = 8'($urandom); r.kind = 8'($urandom); r.text = $urandom;
        r.has_client = 1'($urandom); r.ip = ip; r.mac = mac;
        r.now = $urandom; r.super_v = 1'($urandom);
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            celcs_pkg::CFG_START: start_sec = val;
            celcs_pkg::CFG_PRIV:  nc_priv = val[7:0];
            celcs_pkg::CFG_TYPE:  nc_kind = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_views.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (40) @(posedge aclk); // a trailing search may still be walking
    endtask

    initial begin
        request_t    r;
        logic [31:0] ips [4];
        logic [47:0] macs [4];
        start_sec = 0; nc_priv = 0; nc_kind = 0; oldest = 0; next_slot = 0;
        for (int i = 0; i < 4; i++) begin
            ips[i] = $urandom;
            macs[i] = 48'({$urandom, $urandom});
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        write_reg(celcs_pkg::CFG_START, 32'hFFFF_FFFF);
        write_reg(celcs_pkg::CFG_PRIV, 32'd0);
        write_reg(celcs_pkg::CFG_TYPE, 32'hFF);
        write_reg(CFG_UNUSED, 32'h1234_5678);   // unused index, ignored

        // directed: empty readout, text edge cases, searches, wrap, unused request
        r = make_req(celcs_pkg::REQ_READOUT, '0, '0); r.super_v = 1'b1; r.now = '0;
        pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_LOG, '1, '1); r.text = 32'h0041_7F1F; r.priv = 8'hFF;
        r.has_client = 1'b1; r.now = '1; pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_LOG, '1, '1); r.text = 32'hFF80_0001; r.priv = 8'd0;
        r.has_client = 1'b0; pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_LOG, '0, '0); r.text = 32'h0000_0000; r.priv = 8'd1;
        pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_BEGIN, '1, '1); pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_BEGIN, 32'h0, 48'h0); pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_BEGIN, ips[0], macs[0]); pending_reqs.push_back(r);
        r = make_req(REQ_UNUSED, '0, '0); pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_READOUT, '0, '0); r.super_v = 1'b0;
        pending_reqs.push_back(r);
        r = make_req(celcs_pkg::REQ_READOUT, '0, '0); r.super_v = 1'b1;
        pending_reqs.push_back(r);
        for (int i = 0; i < 14; i++) begin
            r = make_req(celcs_pkg::REQ_LOG, $urandom, 48'({$urandom, $urandom}));
            pending_reqs.push_back(r);
        end
        r = make_req(celcs_pkg::REQ_READOUT, '0, '0); r.super_v = 1'b1;
        pending_reqs.push_back(r);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = (phase == 0) ? 17 : (phase == 1) ? 81 : 0;
            rx_idle = (phase == 0) ? 81 : (phase == 1) ? 17 : 0;
            write_reg(celcs_pkg::CFG_START, (phase == 2) ? 32'd0 : $urandom);
            write_reg(celcs_pkg::CFG_PRIV,
                      (phase == 1) ? 32'hFF : 32'($urandom_range(1)));
            write_reg(celcs_pkg::CFG_TYPE, (phase == 2) ? 32'd0 : $urandom);
            for (int i = 0; i < 65; i++) begin
                int  pick, who;
                pick = $urandom_range(99);
                who = $urandom_range(3);
                if (pick < 45)
                    r = make_req(celcs_pkg::REQ_BEGIN,
                                 ($urandom_range(4) == 0) ? $urandom : ips[who],
                                 ($urandom_range(4) == 0) ? 48'({$urandom, $urandom})
                                                          : macs[who]);
                else if (pick < 70) begin
                    r = make_req(celcs_pkg::REQ_LOG, ips[who], macs[who]);
                    if ($urandom_range(1)) r.priv = 8'd0;
                end else if (pick < 97) r = make_req(celcs_pkg::REQ_READOUT, '0, '0);
                else r = make_req(REQ_UNUSED, $urandom, 48'({$urandom, $urandom}));
                pending_reqs.push_back(r);
            end
            drain();
        end

        $display("Sent %0d requests, checked %0d readout items over %0d readouts",
                 n_sent, n_views, n_readouts);
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

/* sim.f */
sv/celcs_pkg.sv
sv/celcs_cell.sv
sv/circular_event_log_with_client_search_core.sv
sim/tb.sv
